/* design/oklab_to_srgb_xyz_core_assert.svh */
// assertion macros for the oklab to srgb / xyz core
`ifndef OKLAB_TO_SRGB_XYZ_CORE_ASSERT_SVH
`define OKLAB_TO_SRGB_XYZ_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pipeline check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pipeline check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/ok2sx_pkg.sv */
package ok2sx_pkg;

  localparam int GammaTableBits = 8;
  localparam int GtSize         = (1 << GammaTableBits) + 1;
  localparam int IdxW           = GammaTableBits + 1;
  localparam int FracBits       = 20 - GammaTableBits;
  localparam int HalfFrac       = 1 << (FracBits - 1);

  localparam int RootW = 24;
  localparam int SqW   = 25;
  localparam int CubeW = 27;
  localparam int LinW  = 32;
  localparam int AccW  = 32;
  localparam int XyzW  = 24;

  localparam int LinThr  = 3282;
  localparam int LinGain = 846725;
  localparam int EncMul  = 69140;
  localparam int EncOff  = 3604;
  localparam int OneQ20  = 1 << 20;

  typedef logic signed [25:0] lab_coef_t;
  typedef logic signed [27:0] lms_coef_t;
  typedef logic signed [24:0] xyz_coef_t;

  // decimal coefficient (10 fractional digits) to q24, round half up
  function automatic longint dq24(input longint n);
    return (n * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000;
  endfunction

  function automatic logic [63:0] icbrt(input logic [63:0] v);
    logic [63:0] lo, hi, mid;
    lo = '0;
    hi = 64'd1 << 21;
    for (int k = 0; k < 24; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (mid * mid * mid <= v) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] lo, hi, mid;
    lo = '0;
    hi = 64'd1 << 21;
    for (int k = 0; k < 24; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (mid * mid <= v) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // gamma table entry i, q16, 0..65536
  function automatic logic [16:0] gamma_entry(input int unsigned i);
    logic [63:0] x20, c, q, y;
    longint      e;
    x20 = 64'(i) << FracBits;
    if (x20 <= 64'(LinThr)) begin
      e = longint'((x20 * 64'(LinGain) + 64'd524288) >> 20);
    end else begin
      c = icbrt(64'(i) << (60 - GammaTableBits));
      q = isqrt(isqrt(c << 20) << 20);
      y = (c * q + 64'd524288) >> 20;
      e = ((longint'(EncMul) * longint'(y) + 64'sd524288) >>> 20) - longint'(EncOff);
    end
    if (e < 0) e = 0;
    if (e > 65536) e = 65536;
    return 17'(e);
  endfunction

  localparam lab_coef_t LabMat [3][2] = '{
    '{ lab_coef_t'(dq24(64'sd3963377774)),  lab_coef_t'(dq24(64'sd2158037573)) },
    '{ lab_coef_t'(-dq24(64'sd1055613458)), lab_coef_t'(-dq24(64'sd638541728)) },
    '{ lab_coef_t'(-dq24(64'sd894841775)),  lab_coef_t'(-dq24(64'sd12914855480)) }
  };

  localparam lms_coef_t LmsMat [3][3] = '{
    '{ lms_coef_t'(dq24(64'sd40767416621)), lms_coef_t'(-dq24(64'sd33077115913)),
       lms_coef_t'(dq24(64'sd2309699292)) },
    '{ lms_coef_t'(-dq24(64'sd12684380046)), lms_coef_t'(dq24(64'sd26097574011)),
       lms_coef_t'(-dq24(64'sd3413193965)) },
    '{ lms_coef_t'(-dq24(64'sd41960863)), lms_coef_t'(-dq24(64'sd7034186147)),
       lms_coef_t'(dq24(64'sd17076147010)) }
  };

  localparam xyz_coef_t XyzMat [3][3] = '{
    '{ xyz_coef_t'(dq24(64'sd4124564000)), xyz_coef_t'(dq24(64'sd3575761000)),
       xyz_coef_t'(dq24(64'sd1804375000)) },
    '{ xyz_coef_t'(dq24(64'sd2126729000)), xyz_coef_t'(dq24(64'sd7151522000)),
       xyz_coef_t'(dq24(64'sd721750000)) },
    '{ xyz_coef_t'(dq24(64'sd193339000)), xyz_coef_t'(dq24(64'sd585023000)),
       xyz_coef_t'(dq24(64'sd9505041000)) }
  };

endpackage

/* design/ok2sx_lms.sv */
module ok2sx_lms import ok2sx_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [15:0]      lightness_i,
  input  logic signed [15:0]      axis_a_i,
  input  logic signed [15:0]      axis_b_i,
  output logic signed [CubeW-1:0] cube_o [3]
);

  logic signed [15:0]      lt_c;
  logic signed [41:0]      pa_c [3];
  logic signed [41:0]      pb_c [3];
  logic signed [43:0]      sum_c [3];
  logic signed [RootW-1:0] r_d [3];
  logic signed [RootW-1:0] r_q [3];
  logic signed [RootW-1:0] r2_q [3];
  logic signed [47:0]      p2_c [3];
  logic signed [SqW-1:0]   sq_d [3];
  logic signed [SqW-1:0]   sq_q [3];
  logic signed [48:0]      p3_c [3];
  logic signed [CubeW-1:0] cube_d [3];
  logic signed [CubeW-1:0] cube_q [3];

  always_comb begin
    if (lightness_i < 16'sd0) lt_c = 16'sd0;
    else if (lightness_i > 16'sd16384) lt_c = 16'sd16384;
    else lt_c = lightness_i;
  end

  // lms cube roots, q20
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_c[k]  = LabMat[k][0] * axis_a_i;
      pb_c[k]  = LabMat[k][1] * axis_b_i;
      sum_c[k] = (44'(lt_c) <<< 24) + 44'(pa_c[k]) + 44'(pb_c[k]) + 44'sd131072;
      r_d[k]   = RootW'(sum_c[k] >>> 18);
    end
  end

  // square
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p2_c[k] = r_q[k] * r_q[k];
      sq_d[k] = SqW'((p2_c[k] + 48'sd524288) >>> 20);
    end
  end

  // cube
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p3_c[k]   = sq_q[k] * r2_q[k];
      cube_d[k] = CubeW'((p3_c[k] + 49'sd524288) >>> 20);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        r_q[k]    <= r_d[k];
        r2_q[k]   <= r_q[k];
        sq_q[k]   <= sq_d[k];
        cube_q[k] <= cube_d[k];
      end
    end
  end

  assign cube_o = cube_q;

endmodule

/* design/ok2sx_lin.sv */
module ok2sx_lin import ok2sx_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [CubeW-1:0] cube_i [3],
  output logic signed [LinW-1:0]  lin_o [3]
);

  logic signed [54:0]     prod_c [3][3];
  logic signed [56:0]     sum_c [3];
  logic signed [LinW-1:0] lin_d [3];
  logic signed [LinW-1:0] lin_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_c[k][j] = LmsMat[k][j] * cube_i[j];
      end
      sum_c[k] = 57'(prod_c[k][0]) + 57'(prod_c[k][1]) + 57'(prod_c[k][2])
               + 57'sd8388608;
      lin_d[k] = LinW'(sum_c[k] >>> 24);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q <= lin_d;
    end
  end

  assign lin_o = lin_q;

endmodule

/* design/ok2sx_enc.sv */
module ok2sx_enc import ok2sx_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [LinW-1:0] lin_i,
  output logic [15:0]            srgb_o
);

  localparam int ProdW = FracBits + 19;

  logic [16:0]          gtab [GtSize];
  logic [31:0]          lp_c;
  logic [16:0]          lin_res_c;
  logic [IdxW-1:0]      idx_c;
  logic [IdxW-1:0]      idx1_c;
  logic [16:0]          t0_d, t1_d, t0_q, t1_q;
  logic [FracBits-1:0]  fr_d, fr_q;
  logic signed [17:0]   diff_c;
  logic signed [ProdW-1:0] prod_c, res_c;
  logic [15:0]          srgb_d, srgb_q;

  for (genvar g = 0; g < GtSize; g++) begin : g_tab
    assign gtab[g] = gamma_entry(g);
  end

  // linear segment, table lookup or top entry
  always_comb begin
    lp_c      = 32'(lin_i[11:0]) * 32'(LinGain);
    lin_res_c = 17'((lp_c + 32'd524288) >> 20);
    idx_c     = {1'b0, lin_i[19:FracBits]};
    idx1_c    = idx_c + IdxW'(1);
    t0_d      = '0;
    t1_d      = '0;
    fr_d      = '0;
    if (lin_i <= LinThr) begin
      t0_d = (lin_i < 0) ? 17'd0 : lin_res_c;
      t1_d = t0_d;
    end else if (lin_i >= OneQ20) begin
      t0_d = gtab[GtSize-1];
      t1_d = t0_d;
    end else begin
      t0_d = gtab[idx_c];
      t1_d = gtab[idx1_c];
      fr_d = lin_i[FracBits-1:0];
    end
  end

  // interpolate and clamp
  always_comb begin
    diff_c = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
    prod_c = ProdW'(diff_c) * ProdW'($signed({1'b0, fr_q}));
    res_c  = ProdW'($signed({1'b0, t0_q}))
           + ((prod_c + ProdW'(HalfFrac)) >>> FracBits);
    if (res_c < 0) srgb_d = 16'd0;
    else if (res_c > ProdW'(65535)) srgb_d = 16'hffff;
    else srgb_d = res_c[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q   <= t0_d;
      t1_q   <= t1_d;
      fr_q   <= fr_d;
      srgb_q <= srgb_d;
    end
  end

  assign srgb_o = srgb_q;

endmodule

/* design/ok2sx_xyz.sv */
module ok2sx_xyz import ok2sx_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [LinW-1:0] lin_i [3],
  output logic signed [XyzW-1:0] xyz_o [3]
);

  logic signed [56:0]     prod_c [3][3];
  logic signed [58:0]     sum_c [3];
  logic signed [AccW-1:0] acc_d [3];
  logic signed [AccW-1:0] acc_q [3];
  logic signed [XyzW-1:0] xyz_d [3];
  logic signed [XyzW-1:0] xyz_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_c[k][j] = XyzMat[k][j] * lin_i[j];
      end
      sum_c[k] = 59'(prod_c[k][0]) + 59'(prod_c[k][1]) + 59'(prod_c[k][2])
               + 59'sd134217728;
      acc_d[k] = AccW'(sum_c[k] >>> 28);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (acc_q[k] > 32'sd8388607) xyz_d[k] = 24'sh7fffff;
      else if (acc_q[k] < -32'sd8388608) xyz_d[k] = 24'sh800000;
      else xyz_d[k] = acc_q[k][XyzW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
      xyz_q <= xyz_d;
    end
  end

  assign xyz_o = xyz_q;

endmodule

/* design/oklab_to_srgb_xyz_core.sv */
// oklab to gamma srgb and d65 xyz, six register stages
// a taken request passes through every stage register in order before its result is on the outputs
// throughput: one request per cycle; the whole pipeline holds while the output is stalled
// reset: rst_ni low clears all stage valid bits at once; data registers are not reset
// the gamma table is constant logic, so no fill or clearing pass after reset
`include "oklab_to_srgb_xyz_core_assert.svh"

module oklab_to_srgb_xyz_core import ok2sx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] lightness_i,
  input  logic signed [15:0] axis_a_i,
  input  logic signed [15:0] axis_b_i,
  input  logic [15:0]        alpha_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        srgb_red_o,
  output logic [15:0]        srgb_green_o,
  output logic [15:0]        srgb_blue_o,
  output logic signed [23:0] xyz_x_o,
  output logic signed [23:0] xyz_y_o,
  output logic signed [23:0] xyz_z_o,
  output logic [15:0]        alpha_out_o
);

  localparam int Stages = 6;

  // pipeline moves as a whole when the output register is empty or being taken
  logic                    adv;
  logic [Stages-1:0]       vld_q;
  logic [15:0]             alpha_q [Stages];
  logic signed [CubeW-1:0] cube [3];
  logic signed [LinW-1:0]  lin [3];
  logic signed [XyzW-1:0]  xyz [3];
  logic [15:0]             srgb [3];

  assign adv        = !vld_q[Stages-1] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[Stages-1];

  // valid bits follow the data, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // alpha rides alongside in a delay line
  always_ff @(posedge clk_i) begin
    if (adv) begin
      alpha_q[0] <= alpha_in_i;
      for (int s = 1; s < Stages; s++) begin
        alpha_q[s] <= alpha_q[s-1];
      end
    end
  end

  // stages one to three: clamp, first matrix, square, cube
  ok2sx_lms u_lms (
    .clk_i       (clk_i),
    .en_i        (adv),
    .lightness_i (lightness_i),
    .axis_a_i    (axis_a_i),
    .axis_b_i    (axis_b_i),
    .cube_o      (cube)
  );

  // stage four: second matrix to linear rgb
  ok2sx_lin u_lin (
    .clk_i  (clk_i),
    .en_i   (adv),
    .cube_i (cube),
    .lin_o  (lin)
  );

  // stages five and six: gamma lookup then interpolation, per channel
  for (genvar c = 0; c < 3; c++) begin : g_enc
    ok2sx_enc u_enc (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lin_i  (lin[c]),
      .srgb_o (srgb[c])
    );
  end

  // stages five and six: xyz matrix then saturation
  ok2sx_xyz u_xyz (
    .clk_i (clk_i),
    .en_i  (adv),
    .lin_i (lin),
    .xyz_o (xyz)
  );

  assign srgb_red_o   = srgb[0];
  assign srgb_green_o = srgb[1];
  assign srgb_blue_o  = srgb[2];
  assign xyz_x_o      = xyz[0];
  assign xyz_y_o      = xyz[1];
  assign xyz_z_o      = xyz[2];
  assign alpha_out_o  = alpha_q[Stages-1];

  `ASSERT_IMPL(a_stall_blocks_in, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[0])
  `ASSERT_NEXT(a_last_to_out, clk_i, rst_ni, in_ready_o && vld_q[Stages-2], out_valid_o)

endmodule
